// ===== rtl/core/integer_to_radix_digits_unit_defines.svh =====
// Assertion macros shared by the checker of the radix digit unit.
// Plain text only; no dependencies.
`ifndef INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define I2RD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("radix digit unit: same-cycle rule broken");

// Next-cycle implication, disabled while reset is asserted
`define I2RD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("radix digit unit: next-cycle rule broken");

`endif

// ===== rtl/core/i2rd_pkg.sv =====
// Package for the radix digit unit: state type, field widths, ASCII constants
// and the digit-to-character function. No dependencies.
`default_nettype none

package i2rd_pkg;

  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int OUT_TDATA_W = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0]  ASCII_A       = 7'h41;
  localparam logic [CHAR_W-1:0]  ASCII_NINE    = 7'h39;
  localparam logic [CHAR_W-1:0]  ASCII_Z       = 7'h5A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_OUT
  } i2rd_state_e;

  // Digit value 0..35 to '0'-'9' or 'A'-'Z'
  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_LIMIT) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DECIMAL_LIMIT);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/integer_to_radix_digits_unit.sv =====
// Integer to ASCII radix digits: bit-serial divider, digit store, reverse read-out.
// Depends on i2rd_pkg.
//
// Channel | Dir | Fields (low bit first)            | Handshake
// s_axis  | in  | tdata: value, radix, zero padding | tvalid/tready
// m_axis  | out | tdata: digit_char, 0; tlast: last | tvalid/tready
//
// Each digit takes one pass over all VALUE_BITS bits in the restoring divider
// (one quotient bit per cycle). Read-out passes each digit through the single
// registered read port (ST_RD) before it is shown on m_axis (ST_OUT).
// Reset clears the control state; the digit store is not cleared.
// A stall on m_axis holds the current digit; a new request is taken only
// once the last digit of the previous one has left.
`default_nettype none

module integer_to_radix_digits_unit #(
  parameter int VALUE_BITS  = 31,
  parameter int DIGIT_DEPTH = 32,
  localparam int InW = ((VALUE_BITS + i2rd_pkg::RADIX_W + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [InW-1:0]                   s_axis_tdata_i,  // value, radix, pad
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic [i2rd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,  // digit_char, pad
  output logic                                  m_axis_tlast_o   // last
);

  import i2rd_pkg::*;

  localparam int IdxW = $clog2(DIGIT_DEPTH);
  localparam int BitW = $clog2(VALUE_BITS);

  i2rd_state_e st_q, st_d;

  logic [VALUE_BITS-1:0] quo_q;
  logic [DIGIT_W-1:0]    rem_q;
  logic [RADIX_W-1:0]    radix_q;
  logic                  nz_q;
  logic [BitW-1:0]       bit_q;
  logic [IdxW-1:0]       dig_q;
  logic [DIGIT_W-1:0]    rd_q;
  logic [DIGIT_W-1:0]    store_q [DIGIT_DEPTH];

  logic                  in_acc, out_acc;
  logic [RADIX_W-1:0]    radix_in, radix_sat;
  logic [DIGIT_W:0]      partial;
  logic                  ge;
  logic [DIGIT_W-1:0]    rem_next;
  logic                  nz_next, last_bit, stop;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  // Radix clamp to 2..36
  assign radix_in = s_axis_tdata_i[VALUE_BITS +: RADIX_W];
  always_comb begin
    radix_sat = radix_in;
    if (radix_in < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_in > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end
  end

  // One restoring division step
  assign partial  = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge       = partial >= {1'b0, radix_q};
  assign rem_next = ge ? DIGIT_W'(partial - {1'b0, radix_q}) : partial[DIGIT_W-1:0];
  assign nz_next  = nz_q | ge;
  assign last_bit = (bit_q == '0);
  assign stop     = !nz_next || (dig_q == IdxW'(DIGIT_DEPTH - 1));

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (s_axis_tvalid_i) st_d = ST_DIV;
      ST_DIV:  if (last_bit && stop) st_d = ST_RD;
      ST_RD:   st_d = ST_OUT;
      ST_OUT: begin
        if (m_axis_tready_i) begin
          st_d = (dig_q == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (st_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_OUT:  m_axis_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata_o = {{(OUT_TDATA_W - CHAR_W){1'b0}}, to_ascii(rd_q)};
  assign m_axis_tlast_o = (dig_q == '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      nz_q  <= 1'b0;
      bit_q <= '0;
      dig_q <= '0;
    end else begin
      st_q <= st_d;
      if (in_acc) begin
        nz_q  <= 1'b0;
        bit_q <= BitW'(VALUE_BITS - 1);
        dig_q <= '0;
      end else if (st_q == ST_DIV) begin
        if (last_bit) begin
          if (!stop) begin
            nz_q  <= 1'b0;
            bit_q <= BitW'(VALUE_BITS - 1);
            dig_q <= dig_q + 1'b1;
          end
        end else begin
          nz_q  <= nz_next;
          bit_q <= bit_q - 1'b1;
        end
      end else if (out_acc && (dig_q != '0)) begin
        dig_q <= dig_q - 1'b1;
      end
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      quo_q   <= s_axis_tdata_i[VALUE_BITS-1:0];
      radix_q <= radix_sat;
      rem_q   <= '0;
    end else if (st_q == ST_DIV) begin
      quo_q <= {quo_q[VALUE_BITS-2:0], ge};
      rem_q <= last_bit ? '0 : rem_next;
    end
  end

  // Digit store: written at the end of each digit, read back in reverse
  always_ff @(posedge clk_i) begin
    if ((st_q == ST_DIV) && last_bit) begin
      store_q[dig_q] <= rem_next;
    end
    if (st_q == ST_RD) begin
      rd_q <= store_q[dig_q];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/i2rd_checker.sv =====
// Port-level checker for the radix digit unit, bound to every instance of the unit.
// Depends on i2rd_pkg and integer_to_radix_digits_unit_defines.svh.
`default_nettype none
`include "integer_to_radix_digits_unit_defines.svh"

module i2rd_checker #(
  parameter int VALUE_BITS = 31,
  localparam int InW = ((VALUE_BITS + i2rd_pkg::RADIX_W + 7) / 8) * 8
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid_i,
  input wire logic                        s_axis_tready_o,
  input wire logic [InW-1:0]              s_axis_tdata_i,   // value, radix, pad
  input wire logic                        m_axis_tvalid_o,
  input wire logic                        m_axis_tready_i,
  input wire logic [i2rd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o, // digit_char, pad
  input wire logic                        m_axis_tlast_o    // last
);

  import i2rd_pkg::*;

  logic [CHAR_W-1:0]    ch;
  logic                 ch_ok;
  logic                 pad_ok;
  logic                 out_stall, in_wait, in_acc;
  logic [OUT_TDATA_W:0] out_word;

  assign ch    = m_axis_tdata_o[CHAR_W-1:0];
  assign ch_ok = ((ch >= ASCII_ZERO) && (ch <= ASCII_NINE)) ||
                 ((ch >= ASCII_A) && (ch <= ASCII_Z));
  assign pad_ok = (m_axis_tdata_o[OUT_TDATA_W-1] == 1'b0);

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_wait   = s_axis_tvalid_i && !s_axis_tready_o;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_word  = {m_axis_tlast_o, m_axis_tdata_o};

  // A stalled digit holds its character and last flag
  `I2RD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // A waiting request holds its value and radix
  `I2RD_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_wait, s_axis_tvalid_i && $stable(s_axis_tdata_i))

  // Every digit shown is a valid character with zero padding
  `I2RD_ASSERT_IMP(a_char_range, clk_i, rst_ni, m_axis_tvalid_o, ch_ok && pad_ok)

  // No new request while digits are still being delivered
  `I2RD_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)

  // Division takes cycles: no digit and no new request right after a request is taken
  `I2RD_ASSERT_NXT(a_no_early_digit, clk_i, rst_ni, in_acc, !m_axis_tvalid_o && !s_axis_tready_o)

endmodule

bind integer_to_radix_digits_unit i2rd_checker #(.VALUE_BITS(VALUE_BITS)) u_i2rd_checker (.*);

`default_nettype wire
